>>> hdl/rsib_pkg.sv
// Shared types and constants of the rank and select index builder.
// Used by rsib_accum, rsib_emit and rank_select_index_builder; depends on nothing.
`default_nettype none

package rsib_pkg;

   // Fixed geometry and field widths.
   localparam int WORD_BITS  = 64;
   localparam int SLOT_W     = 27;
   localparam int COUNT_W    = 32;
   localparam int ONES_W     = 33;
   localparam int POP_W      = 7;
   localparam int SUB_W      = 11;
   localparam int SUB_FIELDS = 5;
   localparam int PACK_W     = SUB_FIELDS * SUB_W;

   // Default geometry handed to the top level.
   localparam int DEF_RANK_BLOCK_BITS = 512;
   localparam int DEF_RANK_SUB_BITS   = 128;
   localparam int DEF_SELECT_STRIDE   = 4096;

   // Record positions within the per-word bundle, in output order.
   localparam int NUM_REC   = 7;
   localparam int REC_RANK  = 0;
   localparam int REC_ZSEL  = 1;
   localparam int REC_OSEL  = 2;
   localparam int REC_TRAIL = 3;
   localparam int REC_ZSENT = 4;
   localparam int REC_OSENT = 5;
   localparam int REC_TOTAL = 6;

   // Output record kinds.
   typedef enum logic [1:0] {
      KIND_RANK     = 2'd0,
      KIND_ZERO_SEL = 2'd1,
      KIND_ONE_SEL  = 2'd2,
      KIND_TOTAL    = 2'd3
   } kind_type;

   // All results caused by one word, with a mask of the records present.
   typedef struct packed {
      logic [NUM_REC-1:0] mask;
      logic [SLOT_W-1:0]  blk;
      logic [COUNT_W-1:0] total;
      logic [PACK_W-1:0]  subs;
      logic [SLOT_W-1:0]  zslot;
      logic [SLOT_W-1:0]  oslot;
      logic [SLOT_W-1:0]  znext;
      logic [SLOT_W-1:0]  onext;
      logic [COUNT_W-1:0] sent_value;
   } bundle_type;

endpackage

`default_nettype wire

>>> hdl/rsib_accum.sv
// Per-word accumulator: popcount, rank block and select sample state, and the
// bundle of records caused by the current word. Depends on rsib_pkg.
`default_nettype none

module rsib_accum #(
   parameter int RANK_BLOCK_BITS = rsib_pkg::DEF_RANK_BLOCK_BITS,
   parameter int RANK_SUB_BITS   = rsib_pkg::DEF_RANK_SUB_BITS,
   parameter int SELECT_STRIDE   = rsib_pkg::DEF_SELECT_STRIDE
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write,
   input  wire logic [rsib_pkg::COUNT_W-1:0]  csr_total_bits,
   input  wire logic                          take,
   input  wire logic [rsib_pkg::WORD_BITS-1:0] data_word,
   output rsib_pkg::bundle_type               bundle
);

   localparam int WPB   = RANK_BLOCK_BITS / rsib_pkg::WORD_BITS;
   localparam int OFF_W = $clog2(WPB);
   localparam int RES_W = $clog2(SELECT_STRIDE + rsib_pkg::WORD_BITS + 1);
   localparam int SW    = rsib_pkg::SLOT_W;
   localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(WPB - 1);
   localparam logic [RES_W-1:0] STRIDE   = RES_W'(SELECT_STRIDE);

   // Length-derived values, captured at configuration time.
   logic [SW-1:0] wcount_ff, wcount_in;
   logic          exact_ff, exact_in;

   // Stream position and running counts.
   logic [SW-1:0]                 words_seen_ff;
   logic [OFF_W-1:0]              off_ff, off_in;
   logic [SW-1:0]                 blk_ff, blk_in;
   logic [rsib_pkg::ONES_W-1:0]   ones_ff, ones_in;
   logic [rsib_pkg::SUB_W-1:0]    sub_ff [rsib_pkg::SUB_FIELDS];
   logic [rsib_pkg::SUB_W-1:0]    sub_in [rsib_pkg::SUB_FIELDS];
   logic [RES_W-1:0]              res_ff [2];
   logic [RES_W-1:0]              res_in [2];
   logic [SW-1:0]                 slot_ff [2];
   logic [SW-1:0]                 slot_in [2];

   logic [rsib_pkg::COUNT_W-1:0]  n_eff;
   logic                          active, last, off_end, close, trail;
   logic [rsib_pkg::POP_W-1:0]    pop;
   logic [2:0]                    sub_idx;
   logic [2:0]                    sub_lut [2**OFF_W];
   logic [rsib_pkg::SUB_W-1:0]    prefix [rsib_pkg::SUB_FIELDS];
   logic [rsib_pkg::PACK_W-1:0]   packed_subs;
   logic [rsib_pkg::COUNT_W-1:0]  total_sat;
   logic [rsib_pkg::POP_W-1:0]    sel_add [2];
   logic [RES_W-1:0]              res_sum [2];
   logic [1:0]                    hit;

   // Popcount of one byte.
   function automatic logic [3:0] pop8(input logic [7:0] b);
      logic [3:0] n;
      n = '0;
      for (int k = 0; k < 8; k++) begin
         n = n + 4'(b[k]);
      end
      return n;
   endfunction

   // Sub-block of each word offset within a rank block; offsets past the
   // fifth sub-block land in a sink that is never reported.
   for (genvar g = 0; g < 2**OFF_W; g++) begin : g_sub_lut
      localparam int SUB_RAW = g * rsib_pkg::WORD_BITS / RANK_SUB_BITS;
      assign sub_lut[g] = (SUB_RAW > rsib_pkg::SUB_FIELDS) ?
                          3'(rsib_pkg::SUB_FIELDS) : 3'(SUB_RAW);
   end

   // Word count and exact-fit flag of the new length.
   always_comb begin
      n_eff     = (csr_total_bits == '0) ? rsib_pkg::COUNT_W'(1) : csr_total_bits;
      wcount_in = SW'(n_eff[31:6]) + SW'(|n_eff[5:0]);
      exact_in  = (n_eff[5:0] == 6'd0);
   end

   // Popcount as a sum of byte counts.
   always_comb begin
      pop = '0;
      for (int k = 0; k < 8; k++) begin
         pop = pop + rsib_pkg::POP_W'(pop8(data_word[k*8 +: 8]));
      end
   end

   // Position of this word in the stream.
   always_comb begin
      active  = (words_seen_ff < wcount_ff);
      last    = ((words_seen_ff + SW'(1)) == wcount_ff);
      off_end = (off_ff == OFF_LAST);
      close   = off_end || last;
      trail   = last && exact_ff && off_end;
      off_in  = off_end ? '0 : off_ff + OFF_W'(1);
      blk_in  = blk_ff + SW'(off_end);
      sub_idx = sub_lut[off_ff];
   end

   // Sub-block counts and their packed prefix sums, kept modulo 2048.
   always_comb begin
      for (int j = 0; j < rsib_pkg::SUB_FIELDS; j++) begin
         sub_in[j] = sub_ff[j] +
                     ((sub_idx == 3'(j)) ? rsib_pkg::SUB_W'(pop) : '0);
      end
      prefix[0] = sub_in[0];
      for (int j = 1; j < rsib_pkg::SUB_FIELDS; j++) begin
         prefix[j] = prefix[j-1] + sub_in[j];
      end
      packed_subs = '0;
      for (int j = 0; j < rsib_pkg::SUB_FIELDS; j++) begin
         packed_subs[rsib_pkg::PACK_W-1 - j*rsib_pkg::SUB_W -: rsib_pkg::SUB_W] = prefix[j];
      end
   end

   // Running ones count, saturated to the output width.
   always_comb begin
      ones_in   = ones_ff + rsib_pkg::ONES_W'(pop);
      total_sat = ones_in[rsib_pkg::ONES_W-1] ? '1 : ones_in[rsib_pkg::COUNT_W-1:0];
   end

   // Select sampling: zero bits in lane 0, one bits in lane 1.
   always_comb begin
      sel_add[0] = rsib_pkg::POP_W'(rsib_pkg::WORD_BITS) - pop;
      sel_add[1] = pop;
      for (int b = 0; b < 2; b++) begin
         res_sum[b] = res_ff[b] + RES_W'(sel_add[b]);
         hit[b]     = (res_sum[b] >= STRIDE);
         res_in[b]  = hit[b] ? res_sum[b] - STRIDE : res_sum[b];
         slot_in[b] = hit[b] ? slot_ff[b] + SW'(1) : slot_ff[b];
      end
   end

   // Records caused by this word.
   always_comb begin
      bundle.mask                      = '0;
      bundle.mask[rsib_pkg::REC_RANK]  = active && close;
      bundle.mask[rsib_pkg::REC_ZSEL]  = active && hit[0];
      bundle.mask[rsib_pkg::REC_OSEL]  = active && hit[1];
      bundle.mask[rsib_pkg::REC_TRAIL] = active && trail;
      bundle.mask[rsib_pkg::REC_ZSENT] = active && last;
      bundle.mask[rsib_pkg::REC_OSENT] = active && last;
      bundle.mask[rsib_pkg::REC_TOTAL] = active && last;
      bundle.blk        = blk_ff;
      bundle.total      = total_sat;
      bundle.subs       = packed_subs;
      bundle.zslot      = slot_ff[0];
      bundle.oslot      = slot_ff[1];
      bundle.znext      = slot_in[0];
      bundle.onext      = slot_in[1];
      bundle.sent_value = rsib_pkg::COUNT_W'(blk_ff) + rsib_pkg::COUNT_W'(1) +
                          rsib_pkg::COUNT_W'(trail);
   end

   // State update on every accepted word inside the vector.
   always_ff @(posedge clock) begin
      if (reset) begin
         wcount_ff     <= SW'(1);
         exact_ff      <= 1'b0;
         words_seen_ff <= '0;
         off_ff        <= '0;
         blk_ff        <= '0;
         ones_ff       <= '0;
         for (int j = 0; j < rsib_pkg::SUB_FIELDS; j++) begin
            sub_ff[j] <= '0;
         end
         for (int b = 0; b < 2; b++) begin
            res_ff[b]  <= '0;
            slot_ff[b] <= SW'(1);
         end
      end else begin
         if (csr_write) begin
            wcount_ff <= wcount_in;
            exact_ff  <= exact_in;
         end
         if (take && active) begin
            words_seen_ff <= words_seen_ff + SW'(1);
            off_ff        <= off_in;
            blk_ff        <= blk_in;
            ones_ff       <= ones_in;
            for (int j = 0; j < rsib_pkg::SUB_FIELDS; j++) begin
               sub_ff[j] <= close ? '0 : sub_in[j];
            end
            for (int b = 0; b < 2; b++) begin
               res_ff[b]  <= res_in[b];
               slot_ff[b] <= slot_in[b];
            end
         end
      end
   end

endmodule

`default_nettype wire

>>> hdl/rsib_emit.sv
// Result register and record sequencer: holds one word's bundle and sends its
// records lowest position first, one per cycle unless stalled. Uses rsib_pkg.
`default_nettype none

module rsib_emit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   output logic                                take,
   input  wire rsib_pkg::bundle_type           bundle,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [1:0]                          rsp_record_kind,
   output logic [rsib_pkg::SLOT_W-1:0]         rsp_slot,
   output logic [rsib_pkg::COUNT_W-1:0]        rsp_count_value,
   output logic [rsib_pkg::PACK_W-1:0]         rsp_sub_counts_packed,
   output logic                                rsp_last_of_run
);

   rsib_pkg::bundle_type            bundle_ff;
   logic [rsib_pkg::NUM_REC-1:0]    mask_ff, mask_in;
   logic [rsib_pkg::NUM_REC-1:0]    pick;
   logic [2:0]                      sel;
   logic                            busy, one_left, rsp_fire;
   rsib_pkg::kind_type              kind;

   // Lowest pending record goes out first.
   always_comb begin
      sel = '0;
      for (int k = rsib_pkg::NUM_REC - 1; k >= 0; k--) begin
         if (mask_ff[k]) begin
            sel = 3'(k);
         end
      end
      pick = rsib_pkg::NUM_REC'(1) << sel;
   end

   // Handshake: a new item is taken when the register is empty or empties now.
   always_comb begin
      busy      = |mask_ff;
      one_left  = ((mask_ff & (mask_ff - rsib_pkg::NUM_REC'(1))) == '0);
      rsp_valid = busy;
      rsp_fire  = busy && !rsp_stall;
      req_stall = busy && !(rsp_fire && one_left);
      take      = req_valid && !req_stall;
      mask_in   = take ? bundle.mask : (rsp_fire ? (mask_ff & ~pick) : mask_ff);
   end

   // Payload of the selected record.
   always_comb begin
      kind                  = rsib_pkg::KIND_RANK;
      rsp_slot              = bundle_ff.blk;
      rsp_count_value       = bundle_ff.total;
      rsp_sub_counts_packed = '0;
      case (sel)
         3'(rsib_pkg::REC_RANK): begin
            rsp_sub_counts_packed = bundle_ff.subs;
         end
         3'(rsib_pkg::REC_ZSEL): begin
            kind            = rsib_pkg::KIND_ZERO_SEL;
            rsp_slot        = bundle_ff.zslot;
            rsp_count_value = rsib_pkg::COUNT_W'(bundle_ff.blk);
         end
         3'(rsib_pkg::REC_OSEL): begin
            kind            = rsib_pkg::KIND_ONE_SEL;
            rsp_slot        = bundle_ff.oslot;
            rsp_count_value = rsib_pkg::COUNT_W'(bundle_ff.blk);
         end
         3'(rsib_pkg::REC_TRAIL): begin
            rsp_slot = bundle_ff.blk + rsib_pkg::SLOT_W'(1);
         end
         3'(rsib_pkg::REC_ZSENT): begin
            kind            = rsib_pkg::KIND_ZERO_SEL;
            rsp_slot        = bundle_ff.znext;
            rsp_count_value = bundle_ff.sent_value;
         end
         3'(rsib_pkg::REC_OSENT): begin
            kind            = rsib_pkg::KIND_ONE_SEL;
            rsp_slot        = bundle_ff.onext;
            rsp_count_value = bundle_ff.sent_value;
         end
         3'(rsib_pkg::REC_TOTAL): begin
            kind     = rsib_pkg::KIND_TOTAL;
            rsp_slot = '0;
         end
         default: begin
            kind = rsib_pkg::KIND_RANK;
         end
      endcase
      rsp_record_kind = kind;
      rsp_last_of_run = one_left;
   end

   // Pending mask is control; the bundle payload needs no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         bundle_ff <= bundle;
      end
   end

   // Each delivered record retires exactly one pending record.
   a_retire_one: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && !take) |=> ($countones(mask_ff) == $countones($past(mask_ff)) - 1))
      else $error("record retire count mismatch");

   // A pending zero sentinel always has the one sentinel and total behind it.
   a_sentinel_order: assert property (@(posedge clock) disable iff (reset)
      mask_ff[rsib_pkg::REC_ZSENT] |->
         (mask_ff[rsib_pkg::REC_OSENT] && mask_ff[rsib_pkg::REC_TOTAL]))
      else $error("sentinel records out of order");

   // A trailing rank entry only comes with the end-of-vector records.
   a_trail_last: assert property (@(posedge clock) disable iff (reset)
      mask_ff[rsib_pkg::REC_TRAIL] |-> mask_ff[rsib_pkg::REC_TOTAL])
      else $error("trailing rank entry without end of vector");

   // After the last record of a word, output is idle unless a new word loaded.
   a_run_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_last_of_run) |=> (!rsp_valid || $past(take)))
      else $error("records left after last of run");

endmodule

`default_nettype wire

>>> hdl/rank_select_index_builder.sv
// Top level of the rank and select index builder.
// Instantiates rsib_accum and rsib_emit; uses rsib_pkg.
//
// Usage: 64-bit words of a bit vector enter lowest word first on the req_
// channel (valid/stall). Each word updates the popcount, sub-block counts and
// select sample residues and loads the records it causes into a result
// register. Records leave on the rsp_ channel (valid/stall), one per cycle
// while rsp_stall is low, with rsp_last_of_run marking the final record of a
// word. A word that causes no record produces nothing on rsp_. A word's first
// record is presented in the cycle after the word is accepted. A word is
// accepted every cycle while the result register is empty or sends its last
// record in that cycle. Most words cause no record, so the stream runs at one
// word per cycle except while a word's records are being sent.
// The csr_ channel (valid/ready, always ready) writes total_bits; write it
// only while the block is idle. Words past the end of the vector are taken and
// dropped until reset or until a larger total_bits is written.
// Reset (synchronous, active high) sets total_bits and the sample slots to 1,
// clears the other counts and empties the result register. While rsp_stall is
// high the current record holds and req_stall rises, so no word is lost.
`default_nettype none

module rank_select_index_builder #(
   parameter int RANK_BLOCK_BITS = rsib_pkg::DEF_RANK_BLOCK_BITS,
   parameter int RANK_SUB_BITS   = rsib_pkg::DEF_RANK_SUB_BITS,
   parameter int SELECT_STRIDE   = rsib_pkg::DEF_SELECT_STRIDE
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [rsib_pkg::COUNT_W-1:0]    csr_total_bits,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [rsib_pkg::WORD_BITS-1:0]  req_data_word,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [1:0]                           rsp_record_kind,
   output logic [rsib_pkg::SLOT_W-1:0]          rsp_slot,
   output logic [rsib_pkg::COUNT_W-1:0]         rsp_count_value,
   output logic [rsib_pkg::PACK_W-1:0]          rsp_sub_counts_packed,
   output logic                                 rsp_last_of_run
);

   rsib_pkg::bundle_type bundle;
   logic                 take;

   // The length register accepts every write, so csr_ready is tied high.
   assign csr_ready = 1'b1;

   rsib_accum #(
      .RANK_BLOCK_BITS (RANK_BLOCK_BITS),
      .RANK_SUB_BITS   (RANK_SUB_BITS),
      .SELECT_STRIDE   (SELECT_STRIDE)
   ) u_accum (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_valid && csr_ready),
      .csr_total_bits (csr_total_bits),
      .take           (take),
      .data_word      (req_data_word),
      .bundle         (bundle)
   );

   rsib_emit u_emit (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .take                  (take),
      .bundle                (bundle),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_record_kind       (rsp_record_kind),
      .rsp_slot              (rsp_slot),
      .rsp_count_value       (rsp_count_value),
      .rsp_sub_counts_packed (rsp_sub_counts_packed),
      .rsp_last_of_run       (rsp_last_of_run)
   );

endmodule

`default_nettype wire

>>> tb/sv/rank_select_index_builder_tb.sv
// Self-checking testbench of rank_select_index_builder: streams bit-vector words, checks
// every rank, select and total record against a built-in model of the index builder.
// Depends on rsib_pkg and the rank_select_index_builder RTL only.
`default_nettype none

module rank_select_index_builder_tb;

   // Geometry of the instance under test.
   localparam int BLOCK_BITS      = rsib_pkg::DEF_RANK_BLOCK_BITS;
   localparam int SUB_BITS        = rsib_pkg::DEF_RANK_SUB_BITS;
   localparam int STRIDE          = rsib_pkg::DEF_SELECT_STRIDE;
   localparam int WORDS_PER_BLOCK = BLOCK_BITS / rsib_pkg::WORD_BITS;
   localparam int MAX_RESULTS     = 8;
   localparam int RANDOM_WORDS    = 250;
   localparam int SETTLE_CYCLES   = 4;
   localparam int QUIET_LIMIT     = 2000;

   // One index record as it leaves the block.
   typedef struct packed {
      rsib_pkg::kind_type          kind;
      logic [rsib_pkg::SLOT_W-1:0]  slot;
      logic [rsib_pkg::COUNT_W-1:0] count_value;
      logic [rsib_pkg::PACK_W-1:0]  subs;
      logic                         last;
   } index_record_type;

   typedef enum logic {ROW_WORD, ROW_LENGTH} row_kind_type;
   typedef enum logic [1:0] {
      STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY
   } stall_mode_type;

   // A directed row either writes the length or sends a word; a typed count, where
   // given, is the count_value of the last record that the word causes.
   typedef struct packed {
      row_kind_type                 row_kind;
      logic [63:0]                  value;
      logic                         typed;
      logic [rsib_pkg::COUNT_W-1:0] last_count;
   } stim_row_type;

   localparam stim_row_type DIRECTED_ROWS [23] = '{
      // Length 1 after reset: the first word is the last one.
      '{ROW_WORD,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'd64},
      // Past the end of the vector: ignored.
      '{ROW_WORD,   64'h0000_0000_0000_0000, 1'b0, 32'd0},
      // Zero length acts as one bit, so the vector stays closed.
      '{ROW_LENGTH, 64'd0,                   1'b0, 32'd0},
      '{ROW_WORD,   64'h5555_5555_5555_5555, 1'b0, 32'd0},
      // Two full rank blocks: the last word also emits an empty trailing block.
      '{ROW_LENGTH, 64'd1024,                1'b0, 32'd0},
      '{ROW_WORD,   64'h0000_0000_0000_0000, 1'b0, 32'd0},
      '{ROW_WORD,   64'h0000_0000_0000_0001, 1'b0, 32'd0},
      '{ROW_WORD,   64'h8000_0000_0000_0000, 1'b0, 32'd0},
      '{ROW_WORD,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'd0},
      '{ROW_WORD,   64'h5555_5555_5555_5555, 1'b0, 32'd0},
      '{ROW_WORD,   64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 32'd0},
      '{ROW_WORD,   64'h0000_0000_FFFF_FFFF, 1'b0, 32'd0},
      '{ROW_WORD,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'd0},
      '{ROW_WORD,   64'h0000_0000_0000_0000, 1'b0, 32'd0},
      '{ROW_WORD,   64'hFFFF_0000_0000_0000, 1'b0, 32'd0},
      '{ROW_WORD,   64'h0F0F_0F0F_0F0F_0F0F, 1'b0, 32'd0},
      '{ROW_WORD,   64'h8000_0000_0000_0001, 1'b0, 32'd0},
      '{ROW_WORD,   64'h0000_0000_0000_0000, 1'b0, 32'd0},
      '{ROW_WORD,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'd0},
      '{ROW_WORD,   64'h0000_FFFF_0000_0000, 1'b0, 32'd0},
      // Extended by five bits: the pad bits of the last word are counted too.
      '{ROW_LENGTH, 64'd1029,                1'b0, 32'd0},
      '{ROW_WORD,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'd0},
      '{ROW_WORD,   64'h0000_0000_0000_1234, 1'b0, 32'd0}
   };

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [rsib_pkg::COUNT_W-1:0] csr_total_bits = '0;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [63:0]                  req_data_word = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [1:0]                   rsp_record_kind;
   logic [rsib_pkg::SLOT_W-1:0]  rsp_slot;
   logic [rsib_pkg::COUNT_W-1:0] rsp_count_value;
   logic [rsib_pkg::PACK_W-1:0]  rsp_sub_counts_packed;
   logic                         rsp_last_of_run;

   // Model state of the index builder.
   logic [rsib_pkg::COUNT_W-1:0] vec_bits = 32'd1;
   logic [rsib_pkg::SLOT_W-1:0]  words_taken = '0;
   logic [rsib_pkg::ONES_W-1:0]  ones_sum = '0;
   logic [rsib_pkg::SUB_W-1:0]   sub_sums [6] = '{default: '0};
   int unsigned                  select_fill [2] = '{0, 0};
   logic [rsib_pkg::SLOT_W-1:0]  sample_slot [2] = '{27'd1, 27'd1};

   index_record_type   word_records [$];
   index_record_type   pending_records [$];
   index_record_type   want;
   int                 fault_count = 0;
   int                 quiet_cycles = 0;
   int                 burst_left = 0;
   stall_mode_type     stall_mode = STALL_NONE;
   int                 stall_timer = 0;

   rank_select_index_builder #(
      .RANK_BLOCK_BITS(BLOCK_BITS),
      .RANK_SUB_BITS  (SUB_BITS),
      .SELECT_STRIDE  (STRIDE)
   ) dut (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_total_bits       (csr_total_bits),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_data_word        (req_data_word),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_record_kind      (rsp_record_kind),
      .rsp_slot             (rsp_slot),
      .rsp_count_value      (rsp_count_value),
      .rsp_sub_counts_packed(rsp_sub_counts_packed),
      .rsp_last_of_run      (rsp_last_of_run)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_fault(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      fault_count++;
   endtask

   function automatic logic [rsib_pkg::COUNT_W-1:0] sat32(input longint unsigned v);
      return (v > 64'hFFFF_FFFF) ? '1 : v[rsib_pkg::COUNT_W-1:0];
   endfunction

   // Number of words in the vector at the current length.
   function automatic longint unsigned word_limit();
      longint unsigned n;
      n = (vec_bits == 0) ? 1 : vec_bits;
      return (n + rsib_pkg::WORD_BITS - 1) / rsib_pkg::WORD_BITS;
   endfunction

   function automatic bit vector_open();
      return words_taken < word_limit();
   endfunction

   function automatic void add_record(input rsib_pkg::kind_type kind,
                                      input longint unsigned slot,
                                      input logic [rsib_pkg::COUNT_W-1:0] count_value,
                                      input logic [rsib_pkg::PACK_W-1:0] subs);
      index_record_type rec;
      rec.kind        = kind;
      rec.slot        = slot[rsib_pkg::SLOT_W-1:0];
      rec.count_value = count_value;
      rec.subs        = subs;
      rec.last        = 1'b0;
      if (word_records.size() < MAX_RESULTS)
         word_records.push_back(rec);
   endfunction

   // Update the index state with one accepted word and queue the records it causes.
   function automatic void predict_word(input logic [63:0] w, input bit typed,
                                        input logic [rsib_pkg::COUNT_W-1:0] typed_count);
      longint unsigned              n, idx, off, sub, blk, last_blk, k;
      int unsigned                  pop, add;
      bit                           closing;
      logic [rsib_pkg::SUB_W-1:0]   acc;
      logic [rsib_pkg::PACK_W-1:0]  prefixes;
      index_record_type             rec;
      if (!vector_open())
         return;
      n = (vec_bits == 0) ? 1 : vec_bits;
      idx = words_taken;
      pop = $countones(w);
      ones_sum = ones_sum + rsib_pkg::ONES_W'(pop);

      // Sub-block counts; anything past the sixth sub-block lands in the last one.
      off = idx % WORDS_PER_BLOCK;
      sub = off * rsib_pkg::WORD_BITS / SUB_BITS;
      if (sub > 5)
         sub = 5;
      sub_sums[sub] = sub_sums[sub] + rsib_pkg::SUB_W'(pop);

      closing = (idx + 1 == word_limit());
      blk = idx / WORDS_PER_BLOCK;
      word_records.delete();

      // A rank entry closes each block and the vector itself.
      if (off == WORDS_PER_BLOCK - 1 || closing) begin
         acc = '0;
         prefixes = '0;
         for (int j = 0; j < rsib_pkg::SUB_FIELDS; j++) begin
            acc = acc + sub_sums[j];
            prefixes = {prefixes[rsib_pkg::PACK_W-rsib_pkg::SUB_W-1:0], acc};
         end
         add_record(rsib_pkg::KIND_RANK, blk, sat32(ones_sum), prefixes);
         for (int j = 0; j < 6; j++)
            sub_sums[j] = '0;
      end

      // Zero samples first, then one samples.
      for (int b = 0; b < 2; b++) begin
         add = (b == 1) ? pop : rsib_pkg::WORD_BITS - pop;
         select_fill[b] += add;
         if (select_fill[b] >= STRIDE) begin
            select_fill[b] -= STRIDE;
            add_record((b == 1) ? rsib_pkg::KIND_ONE_SEL : rsib_pkg::KIND_ZERO_SEL,
                       sample_slot[b],
                       sat32(idx * rsib_pkg::WORD_BITS / BLOCK_BITS), '0);
            sample_slot[b] = sample_slot[b] + 1'b1;
         end
      end
      words_taken = words_taken + 1'b1;

      // Trailing empty blocks, the two select sentinels and the total.
      if (closing) begin
         last_blk = n / BLOCK_BITS;
         for (k = blk + 1; k <= last_blk && word_records.size() < MAX_RESULTS - 3; k++)
            add_record(rsib_pkg::KIND_RANK, k, sat32(ones_sum), '0);
         add_record(rsib_pkg::KIND_ZERO_SEL, sample_slot[0], sat32(1 + last_blk), '0);
         add_record(rsib_pkg::KIND_ONE_SEL, sample_slot[1], sat32(1 + last_blk), '0);
         add_record(rsib_pkg::KIND_TOTAL, 0, sat32(ones_sum), '0);
      end

      if (word_records.size() > 0) begin
         rec = word_records.pop_back();
         rec.last = 1'b1;
         if (typed)
            rec.count_value = typed_count;
         word_records.push_back(rec);
      end
      foreach (word_records[i])
         pending_records.push_back(word_records[i]);
   endfunction

   function automatic logic [63:0] rand_word();
      logic [63:0] w;
      w = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0: w = '0;
         1: w = '1;
         2: w = 64'd1 << $urandom_range(0, 63);
         3: w = w & {$urandom, $urandom} & {$urandom, $urandom};
         4: w = w | {$urandom, $urandom};
         default: ;
      endcase
      return w;
   endfunction

   // Send one item, in bursts of random length with random gaps in between.
   task automatic send_word(input logic [63:0] w, input bit typed,
                            input logic [rsib_pkg::COUNT_W-1:0] typed_count);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 16);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
            req_data_word <= {$urandom, $urandom};
         end
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data_word <= w;
      do @(posedge clock); while (req_stall);
      burst_left--;
      predict_word(w, typed, typed_count);
   endtask

   // Wait until every expected record has come and the block has gone quiet.
   task automatic settle_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_records.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_length(input logic [rsib_pkg::COUNT_W-1:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_total_bits <= v;
      do @(posedge clock); while (!csr_ready);
      vec_bits = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Receiver stall pattern, switching to a random mode whenever its timer runs out.
   always @(negedge clock) begin
      if (stall_timer == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_timer <= $urandom_range(32, 128);
      end else begin
         stall_timer <= stall_timer - 1;
      end
      case (stall_mode)
         STALL_NONE:     rsp_stall <= 1'b0;
         STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_PERIODIC: rsp_stall <= ((stall_timer % 8) < 3);
         default:        rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // Compare each accepted record with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_records.size() == 0) begin
            report_fault($sformatf("unexpected record kind %0d slot %0d count %0d",
                                   rsp_record_kind, rsp_slot, rsp_count_value));
         end else begin
            want = pending_records.pop_front();
            if (rsp_record_kind !== want.kind)
               report_fault($sformatf("record kind %0d, expected %0d (slot %0d)",
                                      rsp_record_kind, want.kind, want.slot));
            if (rsp_slot !== want.slot)
               report_fault($sformatf("slot %0d, expected %0d (kind %0d)",
                                      rsp_slot, want.slot, want.kind));
            if (rsp_count_value !== want.count_value)
               report_fault($sformatf("count_value %0d, expected %0d (kind %0d slot %0d)",
                                      rsp_count_value, want.count_value, want.kind,
                                      want.slot));
            if (rsp_sub_counts_packed !== want.subs)
               report_fault($sformatf("sub_counts_packed %h, expected %h (slot %0d)",
                                      rsp_sub_counts_packed, want.subs, want.slot));
            if (rsp_last_of_run !== want.last)
               report_fault($sformatf("last_of_run %0b, expected %0b (kind %0d slot %0d)",
                                      rsp_last_of_run, want.last, want.kind, want.slot));
         end
      end
   end

   // Watchdog on cycles in which no handshake completes.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int                           counted_words;
      int                           pick;
      int unsigned                  span;
      logic [rsib_pkg::COUNT_W-1:0] length_bits;
      counted_words = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part.
      for (int r = 0; r < 23; r++) begin
         if (DIRECTED_ROWS[r].row_kind == ROW_LENGTH) begin
            settle_block();
            write_length(DIRECTED_ROWS[r].value[rsib_pkg::COUNT_W-1:0]);
         end else begin
            send_word(DIRECTED_ROWS[r].value, DIRECTED_ROWS[r].typed,
                      DIRECTED_ROWS[r].last_count);
         end
      end

      // Random part: extend the vector and stream to its end, or set a length already reached.
      while (counted_words < RANDOM_WORDS) begin
         settle_block();
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            // A length that does not reach past the words already taken.
            write_length($urandom_range(1, words_taken * rsib_pkg::WORD_BITS));
            repeat ($urandom_range(1, 2)) send_word(rand_word(), 1'b0, '0);
         end else begin
            span = (pick < 8) ? $urandom_range(1, 24) : $urandom_range(25, 64);
            if (pick % 2 == 1)
               length_bits = ((words_taken + span + WORDS_PER_BLOCK - 1) / WORDS_PER_BLOCK)
                             * BLOCK_BITS;
            else
               length_bits = (words_taken + span - 1) * rsib_pkg::WORD_BITS
                             + $urandom_range(1, rsib_pkg::WORD_BITS);
            write_length(length_bits);
            while (vector_open()) begin
               send_word(rand_word(), 1'b0, '0);
               counted_words++;
            end
            repeat ($urandom_range(0, 2)) send_word(rand_word(), 1'b0, '0);
         end
      end

      // Longest length: the vector stays open to the end of the run.
      settle_block();
      write_length('1);
      repeat (24) send_word(rand_word(), 1'b0, '0);
      settle_block();

      if (fault_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire
